// ===== rtl/core/qlb_pkg.sv =====
// ----------------------------------------------------------------------------
// qlb_pkg
// Shared types and constants of the quoted line blanker.
// ----------------------------------------------------------------------------
package qlb_pkg;

   localparam int CP_W        = 21;
   localparam int MARGIN_W    = 5;
   localparam int QCOUNT_W    = 3;
   localparam int QUOTE_REGS  = 4;
   localparam int QUOTE_SLOTS = 4;
   localparam int CSR_IDX_W   = 3;
   localparam int CMDQ_DEPTH  = 4;

   localparam logic [CP_W-1:0] NEWLINE_CP = CP_W'(10);
   localparam logic [CP_W-1:0] SPACE_CP   = CP_W'(32);

   localparam logic [CSR_IDX_W-1:0] CSR_MARGIN       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_QUOTE_COUNT  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_QUOTE_CHAR_A = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_QUOTE_CHAR_B = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_QUOTE_CHAR_C = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_QUOTE_CHAR_D = 3'd5;

   typedef struct packed {
      logic [MARGIN_W-1:0]                   margin;
      logic [QCOUNT_W-1:0]                   quote_count;
      logic [QUOTE_REGS-1:0][CP_W-1:0]       quote_char;
   } cfg_type;

   typedef struct packed {
      logic             write_en;
      logic             out_en;
      logic             blank;
      logic [CP_W-1:0]  final_char;
   } cmd_type;

endpackage

// ===== rtl/core/qlb_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// qlb_cmd_fifo
// Short command queue between the classifier and the release sequencer.
// ----------------------------------------------------------------------------
module qlb_cmd_fifo
   import qlb_pkg::*;
#(
   parameter int W = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  logic [W-1:0] push_data,
   output logic         full,
   input  logic         pop,
   output logic [W-1:0] pop_data,
   output logic         empty
);

   localparam int AW = $clog2(CMDQ_DEPTH);

   logic [W-1:0] mem_ff [CMDQ_DEPTH];
   logic [AW:0]  wr_ptr_ff, wr_ptr_in;
   logic [AW:0]  rd_ptr_ff, rd_ptr_in;

   assign empty    = wr_ptr_ff == rd_ptr_ff;
   assign full     = (wr_ptr_ff[AW-1:0] == rd_ptr_ff[AW-1:0]) &&
                     (wr_ptr_ff[AW] != rd_ptr_ff[AW]);
   assign pop_data = mem_ff[rd_ptr_ff[AW-1:0]];

   assign wr_ptr_in = (push && !full) ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
   assign rd_ptr_in = (pop && !empty) ? rd_ptr_ff + 1'b1 : rd_ptr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push && !full) begin
         mem_ff[wr_ptr_ff[AW-1:0]] <= push_data;
      end
   end

endmodule

// ===== rtl/core/qlb_front.sv =====
// ----------------------------------------------------------------------------
// qlb_front
// Accepts characters, tracks line state and classifies each character into
// a hold or a release command for the back end.
// ----------------------------------------------------------------------------
module qlb_front
   import qlb_pkg::*;
#(
   parameter int MAX_MARGIN = 31,
   parameter int CW         = 5
) (
   input  logic            clock,
   input  logic            reset,
   input  cfg_type         cfg,
   input  logic            req_push,
   output logic            req_full,
   input  logic [CP_W-1:0] req_code_point,
   input  logic            req_end_of_chunk,
   output logic            cmd_push,
   output cmd_type         cmd,
   output logic [CW-1:0]   cmd_count,
   input  logic            cmd_full
);

   localparam int QLIM = (QUOTE_SLOTS < QUOTE_REGS) ? QUOTE_SLOTS : QUOTE_REGS;

   logic [CW-1:0]       held_ff, held_in;
   logic [MARGIN_W-1:0] column_ff, column_in;
   logic                line_start_ff, line_start_in;
   logic                quoted_ff, quoted_in;

   logic [MARGIN_W-1:0] m_eff;
   logic [QCOUNT_W-1:0] n_eff;
   logic                quote_hit;
   logic                q_now;
   logic                col_lt;
   logic                undecided;
   logic                take;

   assign req_full = cmd_full;
   assign take     = req_push && !cmd_full;
   assign cmd_push = take;

   always_comb begin
      m_eff = (32'(cfg.margin) > MAX_MARGIN) ? MARGIN_W'(MAX_MARGIN) : cfg.margin;
      n_eff = (32'(cfg.quote_count) > QLIM) ? QCOUNT_W'(QLIM) : cfg.quote_count;
      quote_hit = 1'b0;
      for (int i = 0; i < QUOTE_REGS; i++) begin
         if ((32'(n_eff) > i) && (cfg.quote_char[i] == req_code_point)) begin
            quote_hit = 1'b1;
         end
      end
   end

   always_comb begin
      q_now     = quoted_ff || (line_start_ff && quote_hit);
      col_lt    = column_ff < m_eff;
      undecided = line_start_ff && col_lt;

      cmd.write_en   = 1'b0;
      cmd.out_en     = 1'b1;
      cmd.blank      = 1'b0;
      cmd.final_char = req_code_point;
      cmd_count      = held_ff;

      held_in       = '0;
      column_in     = column_ff;
      line_start_in = line_start_ff;
      quoted_in     = q_now;

      if (req_code_point == NEWLINE_CP) begin
         cmd.blank     = q_now;
         quoted_in     = 1'b0;
         line_start_in = 1'b1;
         column_in     = '0;
      end else begin
         if (col_lt) begin
            column_in = column_ff + 1'b1;
         end else begin
            line_start_in = 1'b0;
         end
         if (q_now) begin
            cmd.blank      = 1'b1;
            cmd.final_char = SPACE_CP;
         end else if (undecided && (held_ff != CW'(MAX_MARGIN))) begin
            cmd.write_en = 1'b1;
            if (req_end_of_chunk) begin
               cmd.out_en = 1'b1;
            end else begin
               cmd.out_en = 1'b0;
               held_in    = held_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff       <= '0;
         column_ff     <= '0;
         line_start_ff <= 1'b1;
         quoted_ff     <= 1'b0;
      end else if (take) begin
         held_ff       <= held_in;
         column_ff     <= column_in;
         line_start_ff <= line_start_in;
         quoted_ff     <= quoted_in;
      end
   end

endmodule

// ===== rtl/core/qlb_back.sv =====
// ----------------------------------------------------------------------------
// qlb_back
// Holds undecided characters and sequences their release, one result per
// cycle when popped, followed by the final character of each command.
// ----------------------------------------------------------------------------
module qlb_back
   import qlb_pkg::*;
#(
   parameter int MAX_MARGIN = 31,
   parameter int CW         = 5
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            cmd_empty,
   output logic            cmd_pop,
   input  cmd_type         cmd,
   input  logic [CW-1:0]   cmd_count,
   output logic            rsp_empty,
   input  logic            rsp_pop,
   output logic [CP_W-1:0] rsp_out_char,
   output logic            rsp_last
);

   localparam int AW = (MAX_MARGIN > 1) ? $clog2(MAX_MARGIN) : 1;

   logic [CP_W-1:0] held_mem [MAX_MARGIN];
   logic [CP_W-1:0] rd_data_ff;

   logic            busy_ff, busy_in;
   logic [CW-1:0]   idx_ff, idx_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic            blank_ff, blank_in;
   logic [CP_W-1:0] final_ff, final_in;

   logic at_final;
   logic take;

   assign at_final     = idx_ff == cnt_ff;
   assign rsp_empty    = !busy_ff;
   assign rsp_last     = at_final;
   assign rsp_out_char = at_final ? final_ff : (blank_ff ? SPACE_CP : rd_data_ff);

   assign take    = !cmd_empty && (!busy_ff || (rsp_pop && at_final));
   assign cmd_pop = take;

   always_comb begin
      busy_in  = busy_ff;
      idx_in   = idx_ff;
      cnt_in   = cnt_ff;
      blank_in = blank_ff;
      final_in = final_ff;
      if (take) begin
         busy_in  = cmd.out_en;
         idx_in   = '0;
         cnt_in   = cmd_count;
         blank_in = cmd.blank;
         final_in = cmd.final_char;
      end else if (busy_ff && rsp_pop) begin
         if (at_final) begin
            busy_in = 1'b0;
         end else begin
            idx_in = idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      blank_ff <= blank_in;
      final_ff <= final_in;
   end

   always_ff @(posedge clock) begin
      if (take && cmd.write_en) begin
         held_mem[cmd_count[AW-1:0]] <= cmd.final_char;
      end
      rd_data_ff <= held_mem[idx_in[AW-1:0]];
   end

endmodule

// ===== rtl/core/quoted_line_blanker_top.sv =====
// ----------------------------------------------------------------------------
// quoted_line_blanker_top
// Result path: the first result of a character reaches the result ports once
// its command has passed the command queue and the back end's sequencer
// registers, when the back end is idle. Throughput: one character per cycle
// while the queue has room; n held chars give n+1 results, one per pop.
// Reset: clears line state, queue and sequencer, loads register defaults;
// held-character buffer contents stay undefined until written.
// ----------------------------------------------------------------------------
module quoted_line_blanker_top
   import qlb_pkg::*;
#(
   parameter int MAX_MARGIN = 31
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  logic [CP_W-1:0]      req_code_point,
   input  logic                 req_end_of_chunk,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output logic [CP_W-1:0]      rsp_out_char,
   output logic                 rsp_last,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CP_W-1:0]      csr_data
);

   localparam int CW    = $clog2(MAX_MARGIN + 1);
   localparam int CMD_W = $bits(cmd_type) + CW;

   cfg_type cfg_ff, cfg_in;

   logic            f_push, f_full, f_empty, f_pop;
   cmd_type         f_cmd, b_cmd;
   logic [CW-1:0]   f_count, b_count;
   logic [CMD_W-1:0] q_in, q_out;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_MARGIN:       cfg_in.margin        = csr_data[MARGIN_W-1:0];
            CSR_QUOTE_COUNT:  cfg_in.quote_count   = csr_data[QCOUNT_W-1:0];
            CSR_QUOTE_CHAR_A: cfg_in.quote_char[0] = csr_data;
            CSR_QUOTE_CHAR_B: cfg_in.quote_char[1] = csr_data;
            CSR_QUOTE_CHAR_C: cfg_in.quote_char[2] = csr_data;
            CSR_QUOTE_CHAR_D: cfg_in.quote_char[3] = csr_data;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.margin        <= MARGIN_W'(10);
         cfg_ff.quote_count   <= QCOUNT_W'(2);
         cfg_ff.quote_char[0] <= CP_W'(62);
         cfg_ff.quote_char[1] <= CP_W'(124);
         cfg_ff.quote_char[2] <= '0;
         cfg_ff.quote_char[3] <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   qlb_front #(
      .MAX_MARGIN (MAX_MARGIN),
      .CW         (CW)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_code_point   (req_code_point),
      .req_end_of_chunk (req_end_of_chunk),
      .cmd_push         (f_push),
      .cmd              (f_cmd),
      .cmd_count        (f_count),
      .cmd_full         (f_full)
   );

   assign q_in = {f_count, f_cmd};

   qlb_cmd_fifo #(
      .W (CMD_W)
   ) u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (f_push),
      .push_data (q_in),
      .full      (f_full),
      .pop       (f_pop),
      .pop_data  (q_out),
      .empty     (f_empty)
   );

   assign b_count = q_out[CMD_W-1 -: CW];
   assign b_cmd   = q_out[$bits(cmd_type)-1:0];

   qlb_back #(
      .MAX_MARGIN (MAX_MARGIN),
      .CW         (CW)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .cmd_empty    (f_empty),
      .cmd_pop      (f_pop),
      .cmd          (b_cmd),
      .cmd_count    (b_count),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_out_char (rsp_out_char),
      .rsp_last     (rsp_last)
   );

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top - quoted line blanker testbench
// Drives code points into quoted_line_blanker_top through its push/full
// queue port and checks every popped character against a cycle-free line
// predictor kept in step with each accepted transaction and register write.
// The run covers directed lines, the special cases, random register settings
// with random lines under changing idle rates, and a long result stall that
// fills the block.
// ----------------------------------------------------------------------------
module tb_top;
   import qlb_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_MARGIN   = 31;
   localparam int RESET_CYCLES = 9;
   localparam int SETTLE_CYCLES = 8;
   localparam int END_CYCLES   = 40;
   localparam int CYCLE_LIMIT  = 600000;
   localparam int MAX_REPORTS  = 10;

   typedef struct packed {
      logic [CP_W-1:0] out_char;
      logic            last;
   } line_out_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_push = 1'b0;
   logic                 req_full;
   logic [CP_W-1:0]      req_code_point = '0;
   logic                 req_end_of_chunk = 1'b0;
   logic                 rsp_empty;
   logic                 rsp_pop = 1'b0;
   logic [CP_W-1:0]      rsp_out_char;
   logic                 rsp_last;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CP_W-1:0]      csr_data = '0;

   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int unsigned hold_off_left = 0;
   int unsigned cycle_count = 0;
   int unsigned err_count = 0;

   // line predictor state and register copy
   logic [MARGIN_W-1:0] cfg_margin = MARGIN_W'(10);
   logic [QCOUNT_W-1:0] cfg_quote_count = QCOUNT_W'(2);
   logic [CP_W-1:0]     cfg_quote_char [QUOTE_REGS] = '{CP_W'(62), CP_W'(124), '0, '0};
   logic [CP_W-1:0]     ln_held [$];
   int unsigned         ln_column = 0;
   bit                  ln_at_start = 1'b1;
   bit                  ln_quoted = 1'b0;
   logic [CP_W-1:0]     step_chars [$];
   line_out_type        out_char_q [$];

   quoted_line_blanker_top u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_code_point   (req_code_point),
      .req_end_of_chunk (req_end_of_chunk),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_out_char     (rsp_out_char),
      .rsp_last         (rsp_last),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("quoted_line_blanker_top verification failed");
         $finish;
      end
   end

   function automatic void log_mismatch(input string msg);
      err_count++;
      if (err_count <= MAX_REPORTS) $display("[%0t] %s", $realtime, msg);
   endfunction

   function automatic bit is_quote_mark(input logic [CP_W-1:0] c);
      int unsigned n;
      n = cfg_quote_count;
      if (n > QUOTE_SLOTS) n = QUOTE_SLOTS;
      if (n > QUOTE_REGS) n = QUOTE_REGS;
      for (int i = 0; i < n; i++) begin
         if (cfg_quote_char[i] == c) return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic void release_held(input bit blank);
      foreach (ln_held[i]) step_chars = {step_chars, blank ? SPACE_CP : ln_held[i]};
      ln_held.delete();
   endfunction

   function automatic void blank_line_step(input logic [CP_W-1:0] cp, input logic eoc);
      int unsigned  eff_margin;
      bit           undecided;
      line_out_type item;
      eff_margin = (cfg_margin > MAX_MARGIN) ? MAX_MARGIN : cfg_margin;
      step_chars.delete();
      if (ln_at_start && is_quote_mark(cp)) ln_quoted = 1'b1;
      if (cp == NEWLINE_CP) begin
         release_held(ln_quoted);
         step_chars = {step_chars, cp};
         ln_quoted = 1'b0;
         ln_at_start = 1'b1;
         ln_column = 0;
      end else begin
         undecided = ln_at_start && (ln_column < eff_margin);
         if (ln_column < eff_margin) ln_column++;
         else ln_at_start = 1'b0;
         if (ln_quoted) begin
            release_held(1'b1);
            step_chars = {step_chars, SPACE_CP};
         end else if (undecided && ln_held.size() < MAX_MARGIN) begin
            ln_held = {ln_held, cp};
         end else begin
            release_held(1'b0);
            step_chars = {step_chars, cp};
         end
      end
      if (eoc) release_held(1'b0);
      foreach (step_chars[i]) begin
         item.out_char = step_chars[i];
         item.last     = (i == step_chars.size() - 1);
         out_char_q    = {out_char_q, item};
      end
   endfunction

   // result side: random pop, or a long hold-off when requested
   always @(negedge clock) begin
      if (hold_off_left > 0) begin
         rsp_pop <= 1'b0;
         hold_off_left--;
      end else begin
         rsp_pop <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin : check_rsp
      line_out_type want;
      if (!reset && rsp_pop && rsp_empty === 1'b0) begin
         if (out_char_q.size() == 0) begin
            log_mismatch($sformatf("unexpected result out_char %0h last %0b",
                                   rsp_out_char, rsp_last));
         end else begin
            want = out_char_q.pop_front();
            if (rsp_out_char !== want.out_char || rsp_last !== want.last) begin
               log_mismatch($sformatf("mismatch: out_char exp %0h got %0h, last exp %0b got %0b",
                                      want.out_char, rsp_out_char, want.last, rsp_last));
            end
         end
      end
   end

   task automatic send_char(input logic [CP_W-1:0] cp, input logic eoc);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(negedge clock);
      end
      req_push <= 1'b1;
      req_code_point <= cp;
      req_end_of_chunk <= eoc;
      do @(posedge clock); while (req_full !== 1'b0);
      blank_line_step(cp, eoc);
      @(negedge clock);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_char(CP_W'(s[i]), 1'b0);
   endtask

   task automatic drain_results();
      req_push <= 1'b0;
      while (out_char_q.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CP_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      case (idx)
         CSR_MARGIN:       cfg_margin = data[MARGIN_W-1:0];
         CSR_QUOTE_COUNT:  cfg_quote_count = data[QCOUNT_W-1:0];
         CSR_QUOTE_CHAR_A,
         CSR_QUOTE_CHAR_B,
         CSR_QUOTE_CHAR_C,
         CSR_QUOTE_CHAR_D: cfg_quote_char[idx - CSR_QUOTE_CHAR_A] = data;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic apply_config(input int unsigned m, input int unsigned q,
                               input logic [CP_W-1:0] qa, input logic [CP_W-1:0] qb,
                               input logic [CP_W-1:0] qc, input logic [CP_W-1:0] qd);
      csr_write(CSR_MARGIN, {(CP_W - MARGIN_W)'($urandom), MARGIN_W'(m)});
      csr_write(CSR_QUOTE_COUNT, {(CP_W - QCOUNT_W)'($urandom), QCOUNT_W'(q)});
      csr_write(CSR_QUOTE_CHAR_A, qa);
      csr_write(CSR_QUOTE_CHAR_B, qb);
      csr_write(CSR_QUOTE_CHAR_C, qc);
      csr_write(CSR_QUOTE_CHAR_D, qd);
   endtask

   function automatic logic [CP_W-1:0] random_quote_mark();
      case ($urandom_range(0, 7))
         0:       return NEWLINE_CP;
         1:       return '0;
         2:       return CP_W'(21'h10FFFF);
         3:       return '1;
         4:       return CP_W'($urandom);
         default: return CP_W'($urandom_range(33, 126));
      endcase
   endfunction

   function automatic logic [CP_W-1:0] random_body_char();
      case ($urandom_range(0, 9))
         0:       return CP_W'($urandom);
         1:       return cfg_quote_char[$urandom_range(0, QUOTE_REGS - 1)];
         default: return CP_W'($urandom_range(32, 126));
      endcase
   endfunction

   task automatic send_random_line(inout int sent);
      int unsigned len;
      int unsigned n_active;
      int          quote_pos;
      logic [CP_W-1:0] ch;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 40) : $urandom_range(0, 12);
      n_active = (cfg_quote_count > QUOTE_REGS) ? QUOTE_REGS : cfg_quote_count;
      quote_pos = ($urandom_range(0, 1) && n_active > 0) ?
                  $urandom_range(0, int'(cfg_margin) + 1) : -1;
      for (int i = 0; i < len; i++) begin
         ch = (i == quote_pos) ? cfg_quote_char[$urandom_range(0, n_active - 1)]
                               : random_body_char();
         send_char(ch, $urandom_range(0, 11) == 0);
         sent++;
      end
      if ($urandom_range(0, 99) < 85) begin
         send_char(NEWLINE_CP, $urandom_range(0, 11) == 0);
         sent++;
      end
   endtask

   task automatic test_default_lines();
      send_text("> a\n");
      send_text("ab|c\n");
      send_char('0, 1'b0);
      send_char('1, 1'b0);
      send_char(NEWLINE_CP, 1'b0);
      // flush mid-line, then a later quote still blanks the line
      send_char(CP_W'("x"), 1'b0);
      send_char(CP_W'("y"), 1'b1);
      send_char(CP_W'(">"), 1'b0);
      send_char(CP_W'("z"), 1'b0);
      send_char(NEWLINE_CP, 1'b0);
   endtask

   task automatic test_special_cases();
      // quote count above the slot count clamps to four
      drain_results();
      apply_config(31, 7, CP_W'(">"), CP_W'("|"), CP_W'(";"), '1);
      send_text(";\n");
      // newline as quote mark blanks the undecided line
      drain_results();
      apply_config(3, 1, NEWLINE_CP, CP_W'("|"), '0, '0);
      send_text("a\n");
      // margin lowered below the column decides the line at the next char
      drain_results();
      apply_config(10, 2, CP_W'(">"), CP_W'("|"), '0, '0);
      send_text("ab");
      drain_results();
      csr_write(CSR_MARGIN, CP_W'(1));
      send_text("c\n");
   endtask

   task automatic test_random_lines(input int n_items);
      int sent;
      int target;
      sent = 0;
      while (sent < n_items) begin
         drain_results();
         apply_config(($urandom_range(0, 3) == 0) ? 0 :
                      ($urandom_range(0, 2) == 0) ? 31 : $urandom_range(0, 31),
                      ($urandom_range(0, 3) == 0) ? 7 : $urandom_range(0, 4),
                      random_quote_mark(), random_quote_mark(),
                      random_quote_mark(), random_quote_mark());
         target = sent + $urandom_range(20, 40);
         while (sent < target) send_random_line(sent);
      end
   endtask

   task automatic test_full_backpressure();
      drain_results();
      apply_config(0, 0, CP_W'(">"), CP_W'("|"), '0, '0);
      hold_off_left = 300;
      repeat (60) send_char(CP_W'($urandom_range(32, 126)), 1'b0);
      send_char(NEWLINE_CP, 1'b0);
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      send_idle_pct = 24;
      recv_idle_pct = 46;
      test_default_lines();
      test_special_cases();
      test_random_lines(60);
      send_idle_pct = 46;
      recv_idle_pct = 24;
      test_random_lines(60);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_lines(60);
      test_full_backpressure();
      drain_results();
      repeat (END_CYCLES) @(negedge clock);
      if (out_char_q.size() != 0)
         log_mismatch($sformatf("%0d expected results never arrived", out_char_q.size()));
      if (err_count == 0) begin
         $display("quoted_line_blanker_top verification clean");
      end else begin
         $display("quoted_line_blanker_top verification failed");
      end
      $finish;
   end

endmodule
